// ===== sv/versioned_min_coin_change_unit_assert.svh =====
// assertion macros for the versioned minimum-coin unit
`ifndef VERSIONED_MIN_COIN_CHANGE_UNIT_ASSERT_SVH
`define VERSIONED_MIN_COIN_CHANGE_UNIT_ASSERT_SVH

// same-cycle implication on aclk, held off during reset
`define VMCC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vmcc check failed");

// next-cycle implication on aclk, held off during reset
`define VMCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("vmcc check failed");

`endif

// ===== sv/vmcc_pkg.sv =====
// shared types and constants for the versioned minimum-coin unit
package vmcc_pkg;

    localparam int DEF_MAX_VALUE     = 4096;
    localparam int DEF_MAX_COINS     = 1024;
    localparam int DEF_HISTORY_DEPTH = 16;

    localparam int FIELD_W  = 12;
    localparam int MIN_W    = 13;
    localparam int STATUS_W = 2;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] RES_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] RES_HIST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] RES_RANGE     = 2'd2;
    localparam logic [STATUS_W-1:0] RES_TOO_MANY  = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_ADD_RD,
        S_ADD_EV,
        S_Q_HEAD_EV,
        S_Q_CHK,
        S_Q_HIST_EV,
        S_Q_FIN,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic start_add;
        logic reject_full;
        logic reject_bad;
        logic query_oob;
        logic rd_walk;
        logic eval_walk;
        logic rd_head_q;
        logic head_eval_q;
        logic rd_hist;
        logic dec_k;
        logic fin_q;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic coins_full;
        logic coin_bad;
        logic target_oob;
        logic walk_last;
        logic k_zero;
        logic coin_gt_limit;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/vmcc_ctrl.sv =====
// controller state machine for the versioned minimum-coin unit
module vmcc_ctrl import vmcc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (stat.is_query) begin
                    state_next = stat.target_oob ? S_DONE : S_Q_HEAD_EV;
                end else if (stat.coins_full || stat.coin_bad) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_ADD_RD;
                end
            end
            S_ADD_RD:    state_next = S_ADD_EV;
            S_ADD_EV:    state_next = stat.walk_last ? S_DONE : S_ADD_RD;
            S_Q_HEAD_EV: state_next = S_Q_CHK;
            S_Q_CHK:     state_next = stat.k_zero ? S_Q_FIN : S_Q_HIST_EV;
            S_Q_HIST_EV: state_next = stat.coin_gt_limit ? S_Q_CHK : S_Q_FIN;
            S_Q_FIN:     state_next = S_DONE;
            S_DONE: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_CLEAR: cmd.clr_step = 1'b1;
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_DECIDE: begin
                if (stat.is_query) begin
                    if (stat.target_oob) cmd.query_oob = 1'b1;
                    else                 cmd.rd_head_q = 1'b1;
                end else if (stat.coins_full) begin
                    cmd.reject_full = 1'b1;
                end else if (stat.coin_bad) begin
                    cmd.reject_bad = 1'b1;
                end else begin
                    cmd.start_add = 1'b1;
                end
            end
            S_ADD_RD:    cmd.rd_walk     = 1'b1;
            S_ADD_EV:    cmd.eval_walk   = 1'b1;
            S_Q_HEAD_EV: cmd.head_eval_q = 1'b1;
            S_Q_CHK:     cmd.rd_hist     = !stat.k_zero;
            S_Q_HIST_EV: cmd.dec_k       = stat.coin_gt_limit;
            S_Q_FIN:     cmd.fin_q       = 1'b1;
            S_DONE:      cmd.out_load    = stat.out_free;
            default:     cmd             = '0;
        endcase
    end

endmodule

// ===== sv/vmcc_dp.sv =====
// datapath with head and history memories for the versioned minimum-coin unit
module vmcc_dp import vmcc_pkg::*; #(
    parameter int MAX_VALUE     = DEF_MAX_VALUE,
    parameter int MAX_COINS     = DEF_MAX_COINS,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                in_command,
    input  logic [FIELD_W-1:0]  in_coin,
    input  logic [FIELD_W-1:0]  in_target,
    input  logic [FIELD_W-1:0]  in_limit,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [MIN_W-1:0]    out_min,
    output logic [STATUS_W-1:0] out_status
);

    localparam int VW     = $clog2(MAX_VALUE);
    localparam int LW     = $clog2(HISTORY_DEPTH + 1);
    localparam int CIW    = $clog2(MAX_COINS + 1);
    localparam int HDEPTH = MAX_VALUE * HISTORY_DEPTH;
    localparam int HAW    = $clog2(HDEPTH);
    localparam int HEAD_W = LW + VW;
    localparam int HIST_W = CIW + VW;

    // head entry: history length and best count; history entry: coin index and count
    logic [HEAD_W-1:0] head_mem [MAX_VALUE];
    logic [HIST_W-1:0] hist_mem [HDEPTH];

    logic                online_reg;
    logic [FIELD_W-1:0]  last_reg;
    logic                cmd_reg;
    logic [FIELD_W-1:0]  cv_reg, t_reg, l_reg;
    logic                full_reg, bad_reg, oob_reg;
    logic [CIW-1:0]      coins_reg;
    logic [VW-1:0]       j_reg, src_reg, clr_reg;
    logic [LW-1:0]       k_reg;
    logic [HEAD_W-1:0]   head_a_reg, head_b_reg;
    logic [HIST_W-1:0]   hist_q_reg;
    logic [MIN_W-1:0]    res_min_reg, out_min_reg;
    logic [STATUS_W-1:0] res_st_reg, out_st_reg;
    logic                out_valid_reg;

    logic [FIELD_W-1:0] t_dec, l_dec, dmask;
    logic [VW-1:0]      cv_v, t_v, src_addr, head_rd_addr, head_wr_addr;
    logic [LW-1:0]      len_a, len_b;
    logic [VW-1:0]      best_a, best_b, best_src, m_cnt;
    logic               src_reach, j_reach, improve, hist_full, head_we, hist_we;
    logic [HEAD_W-1:0]  head_wr_data;
    logic [HAW-1:0]     hist_wr_addr, hist_rd_addr;
    logic [CIW-1:0]     q_coin;
    logic [VW-1:0]      q_cnt;

    assign dmask = online_reg ? last_reg : '0;
    assign t_dec = in_target ^ dmask;
    assign l_dec = in_limit ^ dmask;

    assign cv_v     = VW'(32'(cv_reg));
    assign t_v      = VW'(32'(t_reg));
    assign src_addr = j_reg - cv_v;

    assign {len_a, best_a} = head_a_reg;
    assign {len_b, best_b} = head_b_reg;
    assign {q_coin, q_cnt} = hist_q_reg;

    // walk step evaluation
    assign src_reach = (src_reg == '0) || (len_a > LW'(1));
    assign best_src  = (src_reg == '0) ? '0 : best_a;
    assign m_cnt     = best_src + VW'(1);
    assign j_reach   = len_b > LW'(1);
    assign improve   = src_reach && !(j_reach && (m_cnt >= best_b));
    assign hist_full = 32'(len_b) >= HISTORY_DEPTH;

    assign head_we      = cmd.clr_step || (cmd.eval_walk && improve && !hist_full);
    assign head_wr_addr = cmd.clr_step ? clr_reg : j_reg;
    assign head_wr_data = cmd.clr_step ? {LW'(1), VW'(0)} : {len_b + LW'(1), m_cnt};
    assign head_rd_addr = cmd.rd_walk ? src_addr : t_v;

    assign hist_we      = cmd.eval_walk && improve && !hist_full;
    assign hist_wr_addr = HAW'(32'(j_reg) * HISTORY_DEPTH + 32'(len_b));
    assign hist_rd_addr = HAW'(32'(t_v) * HISTORY_DEPTH + 32'(k_reg));

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wr_addr] <= head_wr_data;
        if (cmd.rd_walk || cmd.rd_head_q) head_a_reg <= head_mem[head_rd_addr];
        if (cmd.rd_walk) head_b_reg <= head_mem[j_reg];
    end

    always_ff @(posedge aclk) begin
        if (hist_we) hist_mem[hist_wr_addr] <= {coins_reg, m_cnt};
        if (cmd.rd_hist) hist_q_reg <= hist_mem[hist_rd_addr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            online_reg    <= 1'b1;
            last_reg      <= '0;
            coins_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) online_reg <= cfg_wdata;
            if (cmd.clr_step) clr_reg <= clr_reg + VW'(1);
            if (cmd.start_add) coins_reg <= coins_reg + CIW'(1);
            if (cmd.query_oob) last_reg <= '0;
            if (cmd.fin_q) begin
                if (k_reg == '0) last_reg <= '0;
                else             last_reg <= FIELD_W'(32'(q_cnt));
            end
            if (cmd.out_load)  out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg  <= in_command;
            cv_reg   <= in_coin;
            t_reg    <= t_dec;
            l_reg    <= l_dec;
            full_reg <= 32'(coins_reg) >= MAX_COINS;
            bad_reg  <= (in_coin == '0) || (32'(in_coin) >= MAX_VALUE);
            oob_reg  <= 32'(t_dec) >= MAX_VALUE;
        end
        if (cmd.start_add) begin
            j_reg       <= cv_v;
            res_st_reg  <= RES_OK;
            res_min_reg <= '0;
        end
        if (cmd.reject_full) begin
            res_st_reg  <= RES_TOO_MANY;
            res_min_reg <= '0;
        end
        if (cmd.reject_bad) begin
            res_st_reg  <= RES_RANGE;
            res_min_reg <= '0;
        end
        if (cmd.query_oob) begin
            res_st_reg  <= RES_RANGE;
            res_min_reg <= '1;
        end
        if (cmd.rd_walk) src_reg <= src_addr;
        if (cmd.eval_walk) begin
            j_reg <= j_reg + VW'(1);
            if (improve && hist_full) res_st_reg <= RES_HIST_FULL;
        end
        if (cmd.head_eval_q) k_reg <= len_a - LW'(1);
        if (cmd.dec_k) k_reg <= k_reg - LW'(1);
        if (cmd.fin_q) begin
            res_st_reg <= RES_OK;
            if (k_reg != '0)     res_min_reg <= MIN_W'(32'(q_cnt));
            else if (t_reg == '0) res_min_reg <= '0;
            else                 res_min_reg <= '1;
        end
        if (cmd.out_load) begin
            out_min_reg <= res_min_reg;
            out_st_reg  <= res_st_reg;
        end
    end

    assign stat.clr_last      = 32'(clr_reg) == MAX_VALUE - 1;
    assign stat.is_query      = cmd_reg == CMD_QUERY;
    assign stat.coins_full    = full_reg;
    assign stat.coin_bad      = bad_reg;
    assign stat.target_oob    = oob_reg;
    assign stat.walk_last     = 32'(j_reg) == MAX_VALUE - 1;
    assign stat.k_zero        = k_reg == '0;
    assign stat.coin_gt_limit = 32'(q_coin) > 32'(l_reg);
    assign stat.out_free      = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_min    = out_min_reg;
    assign out_status = out_st_reg;

endmodule

// ===== sv/versioned_min_coin_change_unit.sv =====
// top level of the versioned minimum-coin unit
// Builds the unbounded minimum-coin table one coin type at a time and keeps, for
// every amount, a short history of (coin index, best count) improvements. After
// reset a clearing pass sets every history length to one; no item is taken
// until it ends (configuration writes are taken as ever). An add item walks the
// amounts from its coin value up to MAX_VALUE-1, each amount with one head-memory
// read of source and target, then one evaluate and write; a rejected add ends
// without a walk. A query reads the amount's head, then scans its history
// downward from the newest entry, one entry at a time, until an entry fits the
// limit or none is left. Items are handled one at a time; a finished result sits
// in the output register, so the next item can be accepted while it waits to be
// taken. Each item gives exactly one result.
module versioned_min_coin_change_unit import vmcc_pkg::*; #(
    parameter int MAX_VALUE     = DEF_MAX_VALUE,
    parameter int MAX_COINS     = DEF_MAX_COINS,
    parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: online_decode
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // coin_value[11:0], target_value[23:12], coin_limit[35:24]
    input  logic        s_tuser,  // command
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // min_coins[12:0] signed, status[14:13]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic [MIN_W-1:0]    res_min;
    logic [STATUS_W-1:0] res_status;
    logic                add_result;

    // sequencer: clear pass, add walk, query scan, result handoff
    vmcc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // memories, counters and the output register
    vmcc_dp #(
        .MAX_VALUE     (MAX_VALUE),
        .MAX_COINS     (MAX_COINS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_command (s_tuser),
        .in_coin    (s_tdata[11:0]),
        .in_target  (s_tdata[23:12]),
        .in_limit   (s_tdata[35:24]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_min    (res_min),
        .out_status (res_status)
    );

    assign m_tdata = {1'b0, res_status, res_min};

    // statuses that only an add item can give
    assign add_result = (res_status == RES_HIST_FULL) || (res_status == RES_TOO_MANY);

    `include "versioned_min_coin_change_unit_assert.svh"

    // one item at a time: no second accept right after one
    `VMCC_ASSERT_NEXT(a_single_item, s_tvalid && s_tready, !s_tready)
    // an add result never carries an answer
    `VMCC_ASSERT_NOW(a_add_zero, m_tvalid && add_result, res_min == '0)
    // an impossible answer is a plain miss or an out-of-range target
    `VMCC_ASSERT_NOW(a_miss_status, m_tvalid && (res_min == '1), res_status == RES_OK || res_status == RES_RANGE)

endmodule

// ===== tb/sv/coin_table_checker.sv =====
// checker for the versioned minimum-coin unit: predicts each result and compares it
module coin_table_checker import vmcc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          mismatch_count,
    output int          answers_pending,
    output int          answers_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int AMOUNTS = DEF_MAX_VALUE;
    localparam int DEPTH   = DEF_HISTORY_DEPTH;
    localparam logic [MIN_W-1:0] NO_WAY = '1;

    typedef struct packed {
        logic [MIN_W-1:0]    min_coins;
        logic [STATUS_W-1:0] status;
    } answer_t;

    // model copy of the table
    logic [10:0]      hist_coin [AMOUNTS][DEPTH];
    logic [MIN_W-1:0] hist_best [AMOUNTS][DEPTH];
    int               hist_len  [AMOUNTS];
    int               coins_loaded;
    logic [11:0]      last_answer;
    logic             decode_on;
    answer_t          answers_due[$];

    function automatic bit reachable(int v);
        return v == 0 || hist_len[v] > 1;
    endfunction

    function automatic logic [MIN_W-1:0] best_of(int v);
        return hist_best[v][hist_len[v]-1];
    endfunction

    task automatic add_coin_type(input logic [11:0] cv, output logic [STATUS_W-1:0] st);
        logic [MIN_W-1:0] m;
        st = RES_OK;
        if (coins_loaded >= DEF_MAX_COINS) begin
            st = RES_TOO_MANY;
            return;
        end
        if (cv == 0) begin
            st = RES_RANGE;
            return;
        end
        coins_loaded++;
        for (int j = cv; j < AMOUNTS; j++) begin
            if (!reachable(j - cv)) continue;
            m = best_of(j - cv) + MIN_W'(1);
            if (reachable(j) && m >= best_of(j)) continue;
            // dropped improvement, amount keeps its older count
            if (hist_len[j] >= DEPTH) begin
                st = RES_HIST_FULL;
                continue;
            end
            hist_coin[j][hist_len[j]] = coins_loaded[10:0];
            hist_best[j][hist_len[j]] = m;
            hist_len[j]++;
        end
    endtask

    task automatic answer_query(input logic [11:0] tgt, input logic [11:0] lim,
                                output logic [MIN_W-1:0] mc);
        int k;
        if (decode_on) begin
            tgt ^= last_answer;
            lim ^= last_answer;
        end
        k = hist_len[tgt] - 1;
        while (k > 0 && hist_coin[tgt][k] > lim) k--;
        if (k == 0 && tgt != 0) begin
            mc = NO_WAY;
            last_answer = '0;
        end else begin
            mc = hist_best[tgt][k];
            last_answer = mc[11:0];
        end
    endtask

    always @(posedge aclk) begin
        answer_t exp_a, got_a;
        if (!aresetn) begin
            for (int v = 0; v < AMOUNTS; v++) begin
                hist_len[v] = 1;
                hist_coin[v][0] = '0;
                hist_best[v][0] = '0;
            end
            coins_loaded = 0;
            last_answer = '0;
            decode_on = 1'b1;
            answers_due.delete();
            mismatch_count = 0;
            answers_checked = 0;
        end else begin
            if (cfg_we) decode_on = cfg_wdata;
            if (s_tvalid && s_tready) begin
                exp_a = '0;
                if (s_tuser == CMD_ADD)
                    add_coin_type(s_tdata[11:0], exp_a.status);
                else
                    answer_query(s_tdata[23:12], s_tdata[35:24], exp_a.min_coins);
                answers_due = {answers_due, exp_a};
            end
            if (m_tvalid && m_tready) begin
                got_a = {m_tdata[12:0], m_tdata[14:13]};
                answers_checked++;
                if (answers_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: min_coins %0d status %0d",
                                 $signed(got_a.min_coins), got_a.status);
                end else begin
                    exp_a = answers_due.pop_front();
                    if (got_a != exp_a) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: min_coins exp %0d got %0d, status exp %0d got %0d",
                                     $signed(exp_a.min_coins), $signed(got_a.min_coins),
                                     exp_a.status, got_a.status);
                    end
                end
            end
        end
        answers_pending = answers_due.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the versioned minimum-coin unit: stimulus and verdict
module tb import vmcc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 4_000_000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // coin_value[11:0], target_value[23:12], coin_limit[35:24]
    logic        s_tuser;   // command
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // min_coins[12:0], status[14:13]

    int     mismatch_count, answers_pending, answers_checked;
    int     items_sent;
    bit     idle_en;     // random gaps on both sides when set
    int     stall_left;
    longint cycles;

    versioned_min_coin_change_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    coin_table_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .mismatch_count(mismatch_count), .answers_pending(answers_pending),
        .answers_checked(answers_checked)
    );

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // result side back-pressure, changed at the falling edge
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (idle_en && $urandom_range(0, 5) == 0) stall_left <= gap_len();
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // one item, held until taken, then an optional gap with valid low
    task automatic send_item(input logic cmd, input logic [11:0] coin,
                             input logic [11:0] tgt, input logic [11:0] lim);
        int g;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, lim, tgt, coin};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        g = gap_len();
        if (g > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
    endtask

    task automatic add_coin(input logic [11:0] coin);
        send_item(CMD_ADD, coin, 12'($urandom), 12'($urandom));
    endtask

    task automatic ask(input logic [11:0] tgt, input logic [11:0] lim);
        send_item(CMD_QUERY, 12'($urandom), tgt, lim);
    endtask

    // hold the sender until every result is back, then let the unit settle
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (answers_pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_decode(input logic v);
        drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_items(input int n);
        int r;
        logic [11:0] coin, lim;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                // adds mostly use large coins so the walk stays short
                r = $urandom_range(0, 99);
                if (r < 75)      coin = 12'($urandom_range(2048, 4095));
                else if (r < 85) coin = 12'($urandom_range(1, 64));
                else if (r < 95) coin = 12'($urandom_range(65, 2047));
                else             coin = 12'd0;
                add_coin(coin);
            end else begin
                lim = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 40));
                ask(12'($urandom), lim);
            end
        end
    endtask

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = CMD_ADD;
        m_tready   = 1'b0;
        stall_left = 0;
        cycles     = 0;
        items_sent = 0;
        idle_en    = 1'b1;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, bad coin, a run of small coins that fills histories
        ask(12'd0, 12'd0);
        ask(12'd5, 12'd4095);
        add_coin(12'd0);
        for (int c = 1; c <= 17; c++) add_coin(c[11:0]);

        // plain operands for the directed queries
        set_decode(1'b0);
        ask(12'd4095, 12'd0);
        ask(12'd4095, 12'd1);
        ask(12'd4095, 12'd4095);
        ask(12'd0, 12'd4095);
        ask(12'd1234, 12'd8);
        idle_en = 1'b0;
        add_coin(12'd4095);
        ask(12'd4095, 12'd2047);
        idle_en = 1'b1;

        // random traffic across decode settings
        set_decode(1'b1);
        random_items(40);
        set_decode(1'b0);
        random_items(40);
        drain();
        set_decode(1'b1);
        random_items(30);

        // a short burst of back to back adds of the largest coin
        drain();
        idle_en = 1'b0;
        for (int i = 0; i < 4; i++) add_coin(12'd4095);
        ask(12'd4095, 12'd4095);
        idle_en = 1'b1;

        drain();
        $display("covered %0d items and %0d results: adds, queries, both decode modes,",
                 items_sent, answers_checked);
        $display("history overflow, bad coin values and back to back adds");
        if (mismatch_count == 0 && answers_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, answers_pending);
            $display("status: fail");
        end
        $finish;
    end

endmodule
